// ----- src/varint_base127_decoder_assert.svh -----
// Assertion macros for the base-127 varint decoder.
// Expects clk_i and rst_ni in the scope of use.
`ifndef VARINT_BASE127_DECODER_ASSERT_SVH
`define VARINT_BASE127_DECODER_ASSERT_SVH

// Same-cycle implication.
`define VB_ASSERT_NOW(name, cond, conseq, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define VB_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- src/vb127_pkg.sv -----
// Shared types and constants for the base-127 varint decoder.
// No dependencies.
package vb127_pkg;

  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ACC_W     = 56;
  localparam int unsigned VAL_W     = 57;
  localparam int unsigned WGT_W     = 49;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_SRC_FAIL = 2'd2
  } status_e;

  // Stage-one result handed to the accumulator stage.
  typedef struct packed {
    logic [ACC_W-1:0] prod;    // digit times weight
    logic             sub;     // negative value: subtract
    logic             emit;    // item closes a value or aborts
    status_e          status;
  } s1_t;

endpackage

// ----- src/vb127_if.sv -----
// Stream channel interfaces for the base-127 varint decoder.
// Depends on vb127_pkg.
interface vb127_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       source_error;

  modport source (output valid, output byte_in, output source_error, input ready);
  modport sink   (input valid, input byte_in, input source_error, output ready);
endinterface

interface vb127_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vb127_pkg::VAL_W-1:0]     value;
  logic [1:0]                             status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- src/vb127_front.sv -----
// Byte stage: digit extraction, weight tracking, digit multiply.
// Depends on vb127_pkg and vb127_in_if.
module vb127_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              signed_mode_i,
  vb127_in_if.sink          in_i,
  input  logic              s1_ready_i,
  output logic              s1_valid_o,
  output vb127_pkg::s1_t    s1_o
);

  logic [vb127_pkg::WGT_W-1:0] weight_q, weight_d;
  logic [vb127_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                        neg_q, neg_d;
  logic                        s1_valid_q;
  vb127_pkg::s1_t              s1_q, s1_d;

  logic                        accept;
  logic                        first_signed;
  logic [6:0]                  digit;
  logic                        neg;
  logic                        more;
  logic [vb127_pkg::ACC_W-1:0] w127;

  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign first_signed = (cnt_q == '0) && signed_mode_i;
  assign more         = in_i.byte_in[7];
  assign digit        = first_signed ? {1'b0, in_i.byte_in[5:0]} : in_i.byte_in[6:0];
  assign neg          = first_signed ? in_i.byte_in[6] : neg_q;
  assign cnt_inc      = cnt_q + vb127_pkg::CNT_W'(1);
  // w * 127 as shift and subtract
  assign w127 = {weight_q, 7'd0} - {7'd0, weight_q};

  always_comb begin
    weight_d = weight_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    s1_d.prod   = {{(vb127_pkg::ACC_W-7){1'b0}}, digit}
                * {{(vb127_pkg::ACC_W-vb127_pkg::WGT_W){1'b0}}, weight_q};
    s1_d.sub    = neg;
    s1_d.emit   = 1'b0;
    s1_d.status = vb127_pkg::ST_OK;
    if (in_i.source_error) begin
      s1_d.emit   = 1'b1;
      s1_d.status = vb127_pkg::ST_SRC_FAIL;
      weight_d    = vb127_pkg::WGT_W'(1);
      cnt_d       = '0;
      neg_d       = 1'b0;
    end else if (!more) begin
      s1_d.emit = 1'b1;
      weight_d  = vb127_pkg::WGT_W'(1);
      cnt_d     = '0;
      neg_d     = 1'b0;
    end else if (cnt_inc >= vb127_pkg::CNT_W'(vb127_pkg::MAX_BYTES)) begin
      s1_d.emit   = 1'b1;
      s1_d.status = vb127_pkg::ST_TOO_LONG;
      weight_d    = vb127_pkg::WGT_W'(1);
      cnt_d       = '0;
      neg_d       = 1'b0;
    end else begin
      cnt_d    = cnt_inc;
      neg_d    = neg;
      weight_d = first_signed ? vb127_pkg::WGT_W'(63) : w127[vb127_pkg::WGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= vb127_pkg::WGT_W'(1);
      cnt_q      <= '0;
      neg_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      weight_q   <= weight_d;
      cnt_q      <= cnt_d;
      neg_q      <= neg_d;
      s1_valid_q <= 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

// ----- src/vb127_accum.sv -----
// Accumulate stage and result register.
// Depends on vb127_pkg and vb127_out_if.
module vb127_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_valid_i,
  input  vb127_pkg::s1_t    s1_i,
  output logic              s1_ready_o,
  vb127_out_if.source       out_o
);

  logic [vb127_pkg::VAL_W-1:0] acc_q, acc_d, acc_sum;
  logic                        out_valid_q;
  logic [vb127_pkg::VAL_W-1:0] value_q;
  logic [1:0]                  status_q;
  logic                        adv;

  // Items that yield no result never wait on the output side.
  assign s1_ready_o = !s1_i.emit || !out_valid_q || out_o.ready;
  assign adv        = s1_valid_i && s1_ready_o;

  // Negative values are built by subtraction; magnitude stays below 2^56.
  assign acc_sum = s1_i.sub
                 ? acc_q - {1'b0, s1_i.prod}
                 : acc_q + {1'b0, s1_i.prod};

  always_comb begin
    acc_d = acc_q;
    if (adv) begin
      acc_d = s1_i.emit ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (adv && s1_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_i.emit) begin
      value_q  <= (s1_i.status == vb127_pkg::ST_OK) ? acc_sum : '0;
      status_q <= s1_i.status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

endmodule

// ----- src/varint_base127_decoder.sv -----
// Base-127 varint decoder, top level.
// Depends on vb127_pkg, vb127_if, vb127_front, vb127_accum and the assert header.
//
// Usage:
//   in_i  : one encoded byte per transfer (byte_in, source_error).
//   out_o : one decoded integer per finished value (value, status).
//   cfg_we_i / cfg_wdata_i : writes signed_mode; sampled at each value's
//     first byte, so a write between values takes effect on the next one.
// Throughput: one byte per cycle while out_o is not stalled. Each byte goes
//   through a 7x49 digit multiply in the byte stage and one 57-bit add or
//   subtract in the accumulate stage.
// A closing byte passes the byte stage register, then the result register, to out_o.
// Bytes that do not close a value pass the accumulate stage even while
//   out_o is stalled; only a byte that closes or aborts a value waits for
//   the result register. When the receiver holds ready low, in_i.ready
//   drops once such a byte is parked in the byte stage.
// Reset: asynchronous, active low. Clears signed_mode, the partial value,
//   the byte count and all valid flags, and sets the digit weight to one.
// Errors: eight continuing bytes give status 1, a source failure status 2;
//   both give value 0 and restart decoding at the next byte.
`include "varint_base127_decoder_assert.svh"

module varint_base127_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  vb127_in_if.sink      in_i,
  vb127_out_if.source   out_o
);

  logic           signed_mode_q;
  logic           s1_valid;
  logic           s1_ready;
  vb127_pkg::s1_t s1;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  vb127_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode_q),
    .in_i          (in_i),
    .s1_ready_i    (s1_ready),
    .s1_valid_o    (s1_valid),
    .s1_o          (s1)
  );

  vb127_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .s1_ready_o (s1_ready),
    .out_o      (out_o)
  );

  // Error results always carry a zero value.
  `VB_ASSERT_NOW(a_err_zero, out_o.valid && (out_o.status != vb127_pkg::ST_OK),
                 out_o.value == '0, "error result with nonzero value")

  // A source failure transfer lands in the byte stage as an abort.
  `VB_ASSERT_NEXT(a_src_fail, in_i.valid && in_i.ready && in_i.source_error,
                  s1_valid && s1.emit && (s1.status == vb127_pkg::ST_SRC_FAIL),
                  "source failure not flagged in byte stage")

  // A parked item that yields a result blocks input only while output stalls.
  `VB_ASSERT_NOW(a_stall, s1_valid && s1.emit && out_o.valid && !out_o.ready,
                 !in_i.ready, "input accepted over stalled result")

endmodule

// ----- tb/tb_varint_base127_decoder.sv -----
// Self-checking testbench for varint_base127_decoder: directed and random
// byte streams, checked against an in-bench decoding model.
// Depends on vb127_pkg, vb127_if and the decoder RTL.
module tb_varint_base127_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let a non-closing byte clear the pipe before a register write.
  localparam int unsigned SETTLE_CYCLES  = 4;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [vb127_pkg::VAL_W-1:0] value;
    vb127_pkg::status_e                 status;
  } decoded_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  vb127_in_if  in_ch ();
  vb127_out_if out_ch ();

  varint_base127_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Decoder model state, mirrors the block's partial value.
  logic                        signed_mode_q;
  logic [vb127_pkg::ACC_W-1:0] acc_sum;
  logic [vb127_pkg::WGT_W-1:0] digit_wt;
  logic [vb127_pkg::CNT_W-1:0] bytes_seen;
  logic                        neg_sign;

  decoded_t    decoded_q[$];   // values the block still owes us
  int unsigned fail_count;
  int unsigned item_count;     // byte transfers so far
  int unsigned stall_cycles;
  int unsigned rx_hold_cycles; // long receiver hold-off request
  bit          tx_idle_on;
  bit          rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoding model
  // ---------------------------------------------------------------------------
  function automatic void restart_value();
    acc_sum    = '0;
    digit_wt   = 1;
    bytes_seen = '0;
    neg_sign   = 1'b0;
  endfunction

  // One accepted byte; sets produced when the byte closes or aborts a value.
  function automatic void decode_byte(input logic [7:0] b, input logic err,
                                      output bit produced, output decoded_t res);
    logic [6:0]                  dig;
    logic                        first_signed;
    logic [63:0]                 prod;
    logic [63:0]                 next_wt;
    logic [vb127_pkg::VAL_W-1:0] mag;
    dig          = b[6:0];
    first_signed = (bytes_seen == 0) && signed_mode_q;
    produced     = 1'b0;
    res.value    = '0;
    res.status   = vb127_pkg::ST_OK;
    if (err) begin
      // byte content is ignored on a source failure
      restart_value();
      res.status = vb127_pkg::ST_SRC_FAIL;
      produced   = 1'b1;
      return;
    end
    if (first_signed) begin
      neg_sign = dig[6];
      dig[6]   = 1'b0;
    end
    prod    = 64'(dig) * 64'(digit_wt);
    acc_sum = acc_sum + prod[vb127_pkg::ACC_W-1:0];
    if (!b[7]) begin
      mag       = {1'b0, acc_sum};
      res.value = neg_sign ? -mag : mag;   // sign with zero magnitude gives 0
      produced  = 1'b1;
      restart_value();
      return;
    end
    bytes_seen = bytes_seen + 1'b1;
    if (bytes_seen >= vb127_pkg::MAX_BYTES) begin
      restart_value();
      res.status = vb127_pkg::ST_TOO_LONG;
      produced   = 1'b1;
      return;
    end
    if (first_signed) begin
      digit_wt = 63;
    end else begin
      next_wt  = 64'(digit_wt) * 64'd127;
      digit_wt = next_wt[vb127_pkg::WGT_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender. Called at a posedge, returns right after the transfer edge
  // with valid still high so a back-to-back byte needs no extra edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic err = 1'b0);
    int unsigned gap;
    bit          produced;
    decoded_t    res;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_in      <= b;
    in_ch.source_error <= err;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    item_count++;
    decode_byte(b, err, produced, res);
    if (produced) decoded_q.push_back(res);
  endtask

  // Drop valid, wait for every owed value, then let the pipe settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we        <= 1'b0;
    signed_mode_q  = mode;
  endtask

  // ---------------------------------------------------------------------------
  // Random value generation
  // ---------------------------------------------------------------------------
  function automatic logic [6:0] pick_digit();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd63;
      3:       return 7'd64;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // One well-formed value most of the time; otherwise an overlong run,
  // a value cut by a source failure, or a stray byte.
  task automatic send_random_value();
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      len = $urandom_range(1, 8);
      cut = $urandom_range(0, len - 1);
      for (int unsigned i = 0; i < cut; i++) send_byte({1'b1, pick_digit()});
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind < 12) begin
      // eighth continuing byte aborts the value
      for (int unsigned i = 0; i < vb127_pkg::MAX_BYTES; i++)
        send_byte({1'b1, pick_digit()});
    end else if (kind < 17) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end else begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      for (int unsigned i = 0; i < len; i++)
        send_byte({i != len - 1, pick_digit()});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_unsigned_extremes();
    set_mode(1'b0);
    send_byte(8'h00);                                  // zero
    repeat (vb127_pkg::MAX_BYTES - 1) send_byte(8'hFF); // largest value: all digits 127
    send_byte(8'h7F);
    drain();
  endtask

  task automatic test_errors();
    // overlong run, with mixed digits
    send_byte(8'h80);
    repeat (vb127_pkg::MAX_BYTES - 2) send_byte(8'hFF);
    send_byte(8'hC0);
    // source failure mid-value, on a byte with content set
    send_byte(8'h85);
    send_byte(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_signed_extremes();
    set_mode(1'b1);
    send_byte(8'h40);                        // negative zero
    send_byte(8'hFF);                        // sign set, six-bit digit 63
    send_byte(8'h7F);                        // digit 127 at weight 63
    send_byte(8'h3F);                        // largest one-byte positive
    drain();
  endtask

  // The mode is latched at a value's first byte; a write mid-value must not
  // change how the rest of that value is weighted.
  task automatic test_mode_switch_mid_value();
    set_mode(1'b0);
    send_byte(8'h81);
    set_mode(1'b1);
    send_byte(8'h05);
    send_byte(8'hC1);
    set_mode(1'b0);
    send_byte(8'h02);
    drain();
  endtask

  // Receiver holds off long enough that the block fills and drops in ready.
  task automatic test_backpressure();
    tx_idle_on     = 1'b0;
    rx_hold_cycles = 80;
    repeat (40) send_byte({1'b0, pick_digit()});
    drain();
    tx_idle_on = 1'b1;
  endtask

  // Sender stops until all values are back, several times over.
  task automatic test_sender_pause();
    repeat (6) begin
      repeat (3) send_random_value();
      drain();
    end
  endtask

  task automatic test_random(input logic mode, input int unsigned n_bytes,
                             input bit tx_idle, input bit rx_idle);
    int unsigned start;
    set_mode(mode);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    start      = item_count;
    while (item_count - start < n_bytes) send_random_value();
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps per result, plus the long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (out_ch.valid !== 1'b1 && rx_hold_cycles == 0);
      @(posedge clk);
    end
  end

  // Result checker: handshake signals are stable at the falling edge, so a
  // transfer seen here completes at the next rising edge.
  initial begin : result_check
    decoded_t want;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got value %0d status %0d",
                   $time, out_ch.value, out_ch.status);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.value !== want.value) begin
            fail_count++;
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want.value, out_ch.value);
          end
          if (out_ch.status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_ch.status);
          end
        end
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    fail_count     = 0;
    item_count     = 0;
    stall_cycles   = 0;
    rx_hold_cycles = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    signed_mode_q  = 1'b0;
    restart_value();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.byte_in      <= 8'h00;
    in_ch.source_error <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unsigned_extremes();
    test_errors();
    test_signed_extremes();
    test_mode_switch_mid_value();
    test_backpressure();
    test_sender_pause();
    test_random(1'b0, 220, 1'b1, 1'b1);
    test_random(1'b1, 220, 1'b1, 1'b1);
    test_random(1'b0, 170, 1'b0, 1'b0);  // full rate both sides
    test_random(1'b1, 170, 1'b1, 1'b0);

    drain();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
